@@ hw/rtl/tdsv_pkg.sv @@
// shared types and constants of the tridiagonal solver
package tdsv_pkg;

    localparam int DATA_W    = 32;
    localparam int ROW_IDX_W = 6;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_PIV  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;

    // divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/tdsv_ram.sv @@
// generic single-write single-read ram with registered read
module tdsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tdsv_div.sv @@
// bit-serial signed fixed-point divider, (num << frac) / den, truncating, saturated
module tdsv_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [tdsv_pkg::DATA_W-1:0]   num,
    input  logic signed [tdsv_pkg::DATA_W-1:0]   den,
    output tdsv_pkg::div_stat_t                  stat,
    output logic signed [tdsv_pkg::DATA_W-1:0]   quot
);

    localparam int DW = tdsv_pkg::DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int W  = tdsv_pkg::DATA_W;

    logic [W-1:0]  rem_reg, rem_next;
    logic [DW-1:0] q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W-1:0]  abs_num;
    logic [W-1:0]  abs_den;
    logic [W:0]    trial;
    logic          fits;

    assign abs_num = num[W-1] ? W'(-num) : W'(num);
    assign abs_den = den[W-1] ? W'(-den) : W'(den);
    assign trial   = {rem_reg, q_reg[DW-1]};
    assign fits    = trial >= {1'b0, d_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            q_next    = {abs_num, {FRAC_BITS{1'b0}}};
            d_next    = abs_den;
            neg_next  = num[W-1] ^ den[W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
            q_next   = {q_reg[DW-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // saturate magnitude and apply sign
    always_comb begin
        if (!neg_reg) begin
            if (q_reg[DW-1:W-1] != '0) begin
                quot = {1'b0, {(W-1){1'b1}}};
            end else begin
                quot = q_reg[W-1:0];
            end
        end else begin
            if (q_reg[DW-1:W] != '0 || (q_reg[W-1] && q_reg[W-2:0] != '0)) begin
                quot = {1'b1, {(W-1){1'b0}}};
            end else begin
                quot = W'(-q_reg[W-1:0]);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/tridiagonal_solver_core.sv @@
// top level of the streaming thomas-algorithm tridiagonal solver
//
// rows of a tridiagonal system come in on the s_ channel one word each:
// sub, main and super diagonal and right-hand side in signed fixed point,
// s_tlast marks the final row. the forward sweep runs per row and its
// modified super diagonal and rhs go into two rams of MAX_ROWS entries.
// a row's time is set by the bit-serial dividers, one result bit a cycle,
// and no new row is taken until it is done. s_tready is high only
// between rows. a row beyond MAX_ROWS is dropped and flags overflow.
// after the last row the back substitution walks the rams from the top
// index down, a setup step then per solution word a ram read, a multiply
// and a subtract, on m_ with m_tlast on row 0. status rides in m_tuser.
// one output register decouples the sides; when the receiver stalls the
// back substitution waits with its next word until the register frees.
// reset clears control state only; ram contents stay undefined and are
// never used before the current system writes them.
module tridiagonal_solver_core #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // sub_diag, main_diag, super_diag, rhs
    input  logic         s_tlast,   // last_row
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // solution_value, row_index, zero pad
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast    // last_result
);

    localparam int W  = tdsv_pkg::DATA_W;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int SW = 4;

    // controller states
    localparam logic [SW-1:0] S_IDLE   = 4'd0;
    localparam logic [SW-1:0] S_RDW    = 4'd1;
    localparam logic [SW-1:0] S_MUL1   = 4'd2;
    localparam logic [SW-1:0] S_MUL2   = 4'd3;
    localparam logic [SW-1:0] S_PIV    = 4'd4;
    localparam logic [SW-1:0] S_DIVS   = 4'd5;
    localparam logic [SW-1:0] S_DIVW   = 4'd6;
    localparam logic [SW-1:0] S_BSST   = 4'd7;
    localparam logic [SW-1:0] S_BSRDW  = 4'd8;
    localparam logic [SW-1:0] S_BSMUL  = 4'd9;
    localparam logic [SW-1:0] S_BSSUB  = 4'd10;

    logic [SW-1:0] state_reg, state_next;

    // latched row
    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [W-1:0] a_next, b_next, c_next, d_next;
    logic                last_reg, last_next;
    logic                first_reg, first_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    err_reg, err_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic [CW-1:0] cnt_m1;

    logic signed [2*W-1:0] prod1_reg, prod1_next;
    logic signed [2*W-1:0] prod2_reg, prod2_next;
    logic signed [W-1:0]   piv_reg, piv_next;
    logic signed [W-1:0]   numr_reg, numr_next;

    // back substitution
    logic [AW-1:0]       bs_idx_reg, bs_idx_next;
    logic                bs_first_reg, bs_first_next;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] mr_reg, mr_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic signed [W-1:0] m_value_reg, m_value_next;
    logic [AW-1:0]       m_idx_reg, m_idx_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;
    logic                out_load;

    // shared multiplier
    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [2*W-1:0] mul_p;

    // rams
    logic          ram_we;
    logic [W-1:0]  wr_super, wr_rhs;
    logic [W-1:0]  rd_super, rd_rhs;

    // dividers
    logic                div_start;
    tdsv_pkg::div_stat_t div0_stat, div1_stat;
    logic signed [W-1:0] q_super, q_rhs;

    logic s_acc;
    logic signed [W-1:0] piv_calc, num_calc, x_calc;
    logic [AW+5:0]       idx_ext;

    // base - floor(p / 2^frac), saturated to 32 bits
    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] base,
                                                    input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] sh;
        logic signed [2*W:0]   diff;
        sh   = p >>> FRAC_BITS;
        diff = {base[W-1], {W{base[W-1]}}, base} - {sh[2*W-1], sh};
        if (!diff[2*W] && diff[2*W-1:W-1] != '0) begin
            sat_sub = {1'b0, {(W-1){1'b1}}};
        end else if (diff[2*W] && diff[2*W-1:W-1] != '1) begin
            sat_sub = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_sub = diff[W-1:0];
        end
    endfunction

    assign s_acc  = s_tvalid && s_tready;
    assign cnt_m1 = cnt_reg - CW'(1);

    always_comb begin
        case (state_reg)
            S_MUL1:  begin mul_a = a_reg;    mul_b = rd_super; end
            S_MUL2:  begin mul_a = a_reg;    mul_b = rd_rhs;   end
            default: begin mul_a = rd_super; mul_b = x_reg;    end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign piv_calc = first_reg ? b_reg : sat_sub(b_reg, prod1_reg);
    assign num_calc = first_reg ? d_reg : sat_sub(d_reg, prod2_reg);
    assign x_calc   = bs_first_reg ? mr_reg : sat_sub(mr_reg, prod1_reg);

    // zero pivot stores zeros; rows are written well after the previous read
    assign ram_we   = (state_reg == S_DIVS && piv_reg == '0) ||
                      (state_reg == S_DIVW && div0_stat.done);
    assign wr_super = (state_reg == S_DIVW) ? q_super : '0;
    assign wr_rhs   = (state_reg == S_DIVW) ? q_rhs : '0;
    assign div_start = (state_reg == S_DIVS) && (piv_reg != '0);

    assign out_load = (state_reg == S_BSSUB) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        last_next     = last_reg;
        first_next    = first_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        raddr_next    = raddr_reg;
        prod1_next    = prod1_reg;
        prod2_next    = prod2_reg;
        piv_next      = piv_reg;
        numr_next     = numr_reg;
        bs_idx_next   = bs_idx_reg;
        bs_first_next = bs_first_reg;
        x_next        = x_reg;
        mr_next       = mr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_idx_next    = m_idx_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    a_next     = s_tdata[31:0];
                    b_next     = s_tdata[63:32];
                    c_next     = s_tlast ? '0 : s_tdata[95:64];
                    d_next     = s_tdata[127:96];
                    last_next  = s_tlast;
                    first_next = (cnt_reg == '0);
                    raddr_next = cnt_m1[AW-1:0];
                    if (cnt_reg >= CW'(MAX_ROWS)) begin
                        // row dropped, system too large
                        err_next   = tdsv_pkg::STAT_OVERFLOW;
                        state_next = s_tlast ? S_BSST : S_IDLE;
                    end else begin
                        state_next = S_RDW;
                    end
                end
            end
            S_RDW: begin
                state_next = S_MUL1;
            end
            S_MUL1: begin
                prod1_next = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                prod2_next = mul_p;
                state_next = S_PIV;
            end
            S_PIV: begin
                piv_next   = piv_calc;
                numr_next  = num_calc;
                state_next = S_DIVS;
            end
            S_DIVS: begin
                if (piv_reg == '0) begin
                    if (err_reg != tdsv_pkg::STAT_OVERFLOW) begin
                        err_next = tdsv_pkg::STAT_ZERO_PIV;
                    end
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = last_reg ? S_BSST : S_IDLE;
                end else begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div0_stat.done) begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = last_reg ? S_BSST : S_IDLE;
                end
            end
            S_BSST: begin
                bs_idx_next   = cnt_m1[AW-1:0];
                raddr_next    = cnt_m1[AW-1:0];
                bs_first_next = 1'b1;
                state_next    = S_BSRDW;
            end
            S_BSRDW: begin
                state_next = S_BSMUL;
            end
            S_BSMUL: begin
                prod1_next = mul_p;
                mr_next    = rd_rhs;
                state_next = S_BSSUB;
            end
            S_BSSUB: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = x_calc;
                    m_idx_next    = bs_idx_reg;
                    m_status_next = err_reg;
                    m_last_next   = (bs_idx_reg == '0);
                    x_next        = x_calc;
                    bs_first_next = 1'b0;
                    if (bs_idx_reg == '0) begin
                        cnt_next   = '0;
                        err_next   = tdsv_pkg::STAT_OK;
                        state_next = S_IDLE;
                    end else begin
                        bs_idx_next = bs_idx_reg - AW'(1);
                        raddr_next  = bs_idx_reg - AW'(1);
                        state_next  = S_BSRDW;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            err_reg     <= tdsv_pkg::STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        last_reg     <= last_next;
        first_reg    <= first_next;
        raddr_reg    <= raddr_next;
        prod1_reg    <= prod1_next;
        prod2_reg    <= prod2_next;
        piv_reg      <= piv_next;
        numr_reg     <= numr_next;
        bs_idx_reg   <= bs_idx_next;
        bs_first_reg <= bs_first_next;
        x_reg        <= x_next;
        mr_reg       <= mr_next;
        m_value_reg  <= m_value_next;
        m_idx_reg    <= m_idx_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // modified super diagonal store
    tdsv_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_super_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wr_super),
        .raddr (raddr_reg),
        .rdata (rd_super)
    );

    // modified rhs store
    tdsv_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_rhs_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wr_rhs),
        .raddr (raddr_reg),
        .rdata (rd_rhs)
    );

    // the two row divisions run side by side
    tdsv_div #(.FRAC_BITS(FRAC_BITS)) u_div_super (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (c_reg),
        .den     (piv_reg),
        .stat    (div0_stat),
        .quot    (q_super)
    );

    tdsv_div #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (numr_reg),
        .den     (piv_reg),
        .stat    (div1_stat),
        .quot    (q_rhs)
    );

    assign idx_ext  = {6'b0, m_idx_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b0, idx_ext[5:0], m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // row count never passes the store depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ROWS))
        else $error("row count beyond store depth");

    // dividers only work while the controller waits on them, and in lockstep
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (div0_stat.busy || div1_stat.busy) |-> (state_reg == S_DIVW))
        else $error("divider busy outside divide wait");

    a_div_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        div0_stat.done == div1_stat.done)
        else $error("dividers out of step");

    // a solution word never overwrites one still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");

endmodule
